[hdl/ipacl_pkg.sv]
// Shared types, constants and mask functions of the prefix access list matcher.
package ipacl_pkg;

  // Capacity of each rule list and derived widths.
  localparam int MAX_RULES = 256;
  localparam int NUM_LISTS = 3;
  localparam int RULE_DEPTH = NUM_LISTS * MAX_RULES;
  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam int ADDR_W = $clog2(RULE_DEPTH);

  // Fixed field widths of the request and result.
  localparam int PFX_W = 8;
  localparam int HALF_W = 64;
  localparam int V4_W = 32;
  localparam int OUT_CNT_W = 9;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;
  localparam logic [1:0] OP_STATS = 2'd3;

  // List codes.
  localparam logic [1:0] LIST_BLOCK = 2'd0;
  localparam logic [1:0] LIST_ALLOW = 2'd1;
  localparam logic [1:0] LIST_STATS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd2;

  // Prefix limits and the tag word of an IPv4-mapped IPv6 address.
  localparam logic [PFX_W-1:0] V4_MAX_PREFIX = 8'd32;
  localparam logic [PFX_W-1:0] V6_MAX_PREFIX = 8'd128;
  localparam logic [V4_W-1:0] MAPPED_TAG = 32'h0000_FFFF;

  typedef struct packed {
    logic [1:0]        operation;
    logic [1:0]        list_select;
    logic              is_v6;
    logic [PFX_W-1:0]  prefix_bits;
    logic [HALF_W-1:0] addr_hi;
    logic [HALF_W-1:0] addr_lo;
  } acl_in_t;

  typedef struct packed {
    logic                 allowed;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] block_rules;
    logic [OUT_CNT_W-1:0] allow_rules;
  } acl_out_t;

  // One stored rule; host bits are already cleared.
  typedef struct packed {
    logic              is_v6;
    logic [PFX_W-1:0]  prefix;
    logic [HALF_W-1:0] addr_hi;
    logic [HALF_W-1:0] addr_lo;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             exec;
    logic [IDX_W-1:0] rd_idx;
    logic             acc;
    logic             out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             is_check;
    logic [CNT_W-1:0] scan_len;
  } dp_stat_t;

  // Network mask of an IPv4 prefix.
  function automatic logic [V4_W-1:0] v4_mask(input logic [PFX_W-1:0] p);
    logic [V4_W-1:0] m;
    m = (p >= V4_MAX_PREFIX) ? '1 : ~({V4_W{1'b1}} >> p);
    return m;
  endfunction

  // Network mask of an IPv6 prefix over all 128 bits.
  function automatic logic [2*HALF_W-1:0] v6_mask(input logic [PFX_W-1:0] p);
    logic [2*HALF_W-1:0] m;
    m = (p >= V6_MAX_PREFIX) ? '1 : ~({(2*HALF_W){1'b1}} >> p);
    return m;
  endfunction

endpackage

[hdl/ip_prefix_acl_matcher.sv]
// Top level of the prefix access list matcher: controller plus datapath.
//
//   Channel  Ports                           Direction  Moves
//   in       in_valid, in_ready, in_data     input      one request per item
//   out      out_valid, out_ready, out_data  output     one result per request
//
// A clear, an add or a check of an empty list goes from the execute state to
// the finish state. A check of a list of n rules goes through execute, a scan
// that reads the rules at one per cycle, a drain for the last registered read
// and finish. Finish loads the result register and raises out_valid.
// The next request can be taken in the cycle after the result is loaded.
// Reset clears the list counts; no memory clearing pass is needed.
// A new request is taken while a result still waits in the output register;
// it then holds at its end until that result is taken.
module ip_prefix_acl_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipacl_pkg::acl_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipacl_pkg::acl_out_t out_data
);
  import ipacl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencing.
  ipacl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and matching.
  ipacl_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[hdl/ipacl_ram.sv]
// Generic single-port RAM with registered read data.
module ipacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write at the address, and register the word read from it for the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/ipacl_ctrl.sv]
// Controller state machine: sequences execute, list scan and result hand-off.
module ipacl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ipacl_pkg::dp_stat_t   stat,
  output ipacl_pkg::ctrl_cmd_t  cmd
);
  import ipacl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             dv_r, dv_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_idx;
  logic             can_load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign last_idx  = (CNT_W'(idx_r) == (stat.scan_len - CNT_W'(1)));
  assign can_load  = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    dv_nxt       = 1'b0;
    cmd          = '0;
    cmd.rd_idx   = idx_r;
    cmd.acc      = dv_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        idx_nxt  = '0;
        if (stat.is_check && (stat.scan_len != '0)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        dv_nxt    = 1'b1;
        idx_nxt   = idx_r + IDX_W'(1);
        if (last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (can_load) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag: set on load, cleared when the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

endmodule

[hdl/ipacl_dp.sv]
// Datapath: request register, list counts, rule memory, matcher and result register.
module ipacl_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ipacl_pkg::acl_in_t   in_data,
  input  ipacl_pkg::ctrl_cmd_t cmd,
  output ipacl_pkg::dp_stat_t  stat,
  output ipacl_pkg::acl_out_t  out_data
);
  import ipacl_pkg::*;

  acl_in_t          item_r;
  acl_out_t         out_r;
  logic [CNT_W-1:0] cnt_r [NUM_LISTS];
  logic [CNT_W-1:0] cnt_nxt [NUM_LISTS];
  logic             hit_r, hit_nxt;
  logic [1:0]       status_r, status_nxt;

  logic             sel_ok;
  logic [CNT_W-1:0] sel_cnt;
  logic             bad_pfx;
  logic             full;
  logic             is_add;
  logic             do_write;
  logic [1:0]       scan_list;
  logic [CNT_W-1:0] scan_cnt;
  logic [ADDR_W-1:0] wr_addr, rd_addr, ram_addr;
  rule_t            wr_rule, rd_rule;
  logic [2*HALF_W-1:0] m6;
  logic [V4_W-1:0]  m4;
  logic [V4_W-1:0]  ip4;
  logic             mapped;
  logic             use_v4, use_v6;
  logic             rule_hit;
  logic             allowed;

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Count of the list named by the request.
  assign sel_ok = (32'(item_r.list_select) < NUM_LISTS);
  always_comb begin
    case (item_r.list_select)
      LIST_BLOCK: sel_cnt = cnt_r[LIST_BLOCK];
      LIST_ALLOW: sel_cnt = cnt_r[LIST_ALLOW];
      LIST_STATS: sel_cnt = cnt_r[LIST_STATS];
      default:    sel_cnt = '0;
    endcase
  end

  // Add checks: prefix length first, then fullness.
  assign is_add   = (item_r.operation == OP_ADD);
  assign bad_pfx  = item_r.prefix_bits > (item_r.is_v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX);
  assign full     = (sel_cnt >= CNT_W'(MAX_RULES));
  assign do_write = cmd.exec && is_add && sel_ok && !bad_pfx && !full;

  always_comb begin
    status_nxt = status_r;
    if (cmd.exec) begin
      status_nxt = ST_OK;
      if (is_add && sel_ok) begin
        if (bad_pfx) begin
          status_nxt = ST_BAD_PREFIX;
        end else if (full) begin
          status_nxt = ST_FULL;
        end
      end
    end
  end

  // List counts: clear or increment the selected list.
  always_comb begin
    for (int i = 0; i < NUM_LISTS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (cmd.exec && sel_ok && (32'(item_r.list_select) == i)) begin
        if (item_r.operation == OP_CLEAR) begin
          cnt_nxt[i] = '0;
        end else if (do_write) begin
          cnt_nxt[i] = cnt_r[i] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // List to scan for a check or a stats request, and its length.
  always_comb begin
    if (item_r.operation == OP_STATS) begin
      scan_list = LIST_STATS;
      scan_cnt  = cnt_r[LIST_STATS];
    end else if (cnt_r[LIST_ALLOW] != '0) begin
      scan_list = LIST_ALLOW;
      scan_cnt  = cnt_r[LIST_ALLOW];
    end else begin
      scan_list = LIST_BLOCK;
      scan_cnt  = cnt_r[LIST_BLOCK];
    end
  end

  assign stat.is_check = (item_r.operation == OP_CHECK) || (item_r.operation == OP_STATS);
  assign stat.scan_len = scan_cnt;

  // Rule to store, with the host bits cleared.
  assign m6 = v6_mask(item_r.prefix_bits);
  assign m4 = v4_mask(item_r.prefix_bits);
  always_comb begin
    wr_rule.is_v6  = item_r.is_v6;
    wr_rule.prefix = item_r.prefix_bits;
    if (item_r.is_v6) begin
      wr_rule.addr_hi = item_r.addr_hi & m6[2*HALF_W-1:HALF_W];
      wr_rule.addr_lo = item_r.addr_lo & m6[HALF_W-1:0];
    end else begin
      wr_rule.addr_hi = '0;
      wr_rule.addr_lo = HALF_W'(item_r.addr_lo[V4_W-1:0] & m4);
    end
  end

  // Rule memory: one region of MAX_RULES entries per list.
  assign wr_addr  = ADDR_W'(ADDR_W'(item_r.list_select) * ADDR_W'(MAX_RULES)
                            + ADDR_W'(sel_cnt));
  assign rd_addr  = ADDR_W'(ADDR_W'(scan_list) * ADDR_W'(MAX_RULES)
                            + ADDR_W'(cmd.rd_idx));
  assign ram_addr = do_write ? wr_addr : rd_addr;

  ipacl_ram #(
    .WIDTH (RULE_W),
    .DEPTH (RULE_DEPTH)
  ) u_rules (
    .clk   (clk),
    .we    (do_write),
    .addr  (ram_addr),
    .wdata (wr_rule),
    .rdata (rd_rule)
  );

  // Address forms to test: native family, plus the embedded IPv4 of a mapped address.
  assign mapped = (item_r.addr_hi == '0) &&
                  (item_r.addr_lo[HALF_W-1:V4_W] == MAPPED_TAG) &&
                  (item_r.addr_lo[V4_W-1:0] != '0);
  assign ip4    = item_r.addr_lo[V4_W-1:0];
  assign use_v6 = (item_r.operation == OP_CHECK) && item_r.is_v6;
  assign use_v4 = (item_r.operation == OP_STATS) || !item_r.is_v6 || mapped;

  // Match of the rule read out of memory.
  always_comb begin
    if (rd_rule.is_v6) begin
      rule_hit = use_v6 &&
        ((({item_r.addr_hi, item_r.addr_lo} & v6_mask(rd_rule.prefix))
          == {rd_rule.addr_hi, rd_rule.addr_lo}));
    end else begin
      rule_hit = use_v4 &&
        ((ip4 & v4_mask(rd_rule.prefix)) == rd_rule.addr_lo[V4_W-1:0]);
    end
  end

  // Hit flag collected over the scan.
  always_comb begin
    hit_nxt = hit_r;
    if (cmd.exec) begin
      hit_nxt = 1'b0;
    end else if (cmd.acc && rule_hit) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    hit_r    <= hit_nxt;
    status_r <= status_nxt;
  end

  // Verdict of the request.
  always_comb begin
    case (item_r.operation)
      OP_CHECK: begin
        if (cnt_r[LIST_ALLOW] != '0) begin
          allowed = hit_r;
        end else if (cnt_r[LIST_BLOCK] != '0) begin
          allowed = !hit_r;
        end else begin
          allowed = 1'b1;
        end
      end
      OP_STATS: allowed = hit_r;
      default:  allowed = 1'b0;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.allowed     <= allowed;
      out_r.status      <= status_r;
      out_r.block_rules <= OUT_CNT_W'(cnt_r[LIST_BLOCK]);
      out_r.allow_rules <= OUT_CNT_W'(cnt_r[LIST_ALLOW]);
    end
  end

  assign out_data = out_r;

endmodule
